FILE: rtl/trapezoid_speed_profile_macros.svh
// Assertion macros shared by the speed profile RTL.
`ifndef TRAPEZOID_SPEED_PROFILE_MACROS_SVH
`define TRAPEZOID_SPEED_PROFILE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define TSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define TSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tsp_pkg.sv
// Package with the shared types and constants of the speed profile generator.
`timescale 1ns / 1ps

package tsp_pkg;

	localparam int unsigned DEF_LEVEL_WIDTH = 16;
	localparam int unsigned DEF_COUNT_WIDTH = 16;

	localparam int unsigned SETPOINT_W = 16;
	localparam int unsigned PHASE_W    = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned LEVEL_RESET = 5000;
	localparam int unsigned TICKS_RESET = 1000;

	typedef enum logic [PHASE_W-1:0] {
		PH_REST = 2'd0,
		PH_RISE = 2'd1,
		PH_HOLD = 2'd2,
		PH_FALL = 2'd3
	} tsp_phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL = 3'd0,
		REG_REST  = 3'd1,
		REG_RISE  = 3'd2,
		REG_HOLD  = 3'd3,
		REG_FALL  = 3'd4
	} tsp_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tsp_div_stat_t;

endpackage

FILE: rtl/tsp_if.sv
// Handshake channel interfaces: control tick in, setpoint out, register writes.
`timescale 1ns / 1ps

interface tsp_in_if import tsp_pkg::*;;
	logic valid;
	logic ready;
	logic run;

	modport source (output valid, output run, input ready);
	modport sink (input valid, input run, output ready);
endinterface

interface tsp_out_if import tsp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [SETPOINT_W-1:0] setpoint;
	logic [PHASE_W-1:0]    phase;

	modport source (output valid, output setpoint, output phase, input ready);
	modport sink (input valid, input setpoint, input phase, output ready);
endinterface

interface tsp_cfg_if import tsp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tsp_div.sv
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module tsp_div import tsp_pkg::*; #(
	parameter int unsigned Q_W   = DEF_LEVEL_WIDTH,
	parameter int unsigned DEN_W = DEF_COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [Q_W+DEN_W-1:0] dividend,
	input  logic [DEN_W-1:0]   divisor,
	output logic [Q_W-1:0]     quotient,
	output tsp_div_stat_t      stat
);

	localparam int unsigned CNT_W = $clog2(Q_W + 1);

	// The caller guarantees quotient < 2**Q_W, so the upper part is below the divisor.
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   work_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	assign trial = {rem_q, work_q[Q_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != CNT_W'(1));
				done_q <= (cnt_q == CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[Q_W+DEN_W-1:Q_W];
			work_q <= dividend[Q_W-1:0];
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			work_q <= {work_q[Q_W-2:0], fits};
		end
	end

	assign quotient  = work_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/trapezoid_speed_profile.sv
// Top level of the trapezoidal speed profile generator.
`timescale 1ns / 1ps
`include "trapezoid_speed_profile_macros.svh"

// Usage
// Each transfer on the tick channel is one control tick carrying the run flag. For every
// tick the block returns exactly one transfer on the result channel holding the speed
// setpoint for that tick and the phase after it (rest, rise, hold or fall).
// The cfg channel writes the five profile registers by index (level, rest, rise, hold,
// fall); it is always ready and should only be used while no tick is in flight.
// Timing: tick.ready is high only while the sequencer is idle. A tick at rest, on the
// plateau or at the end of a phase needs no arithmetic; it passes through S_DONE into
// the output register, and the sequencer then returns to idle for the next tick. A
// tick on a ramp registers level times the ramp numerator (the count on the rise, the
// remaining ticks on the fall), then runs the shared restoring divider, one quotient
// bit per cycle, and that divider sets the tick rate.
// A new tick may be accepted while the previous result still waits to be taken.
// If the receiver stalls, a finished result waits in the sequencer until the output
// register is free, and no further tick is accepted meanwhile.
// Reset puts the profile at rest with a zero tick count and loads the registers with a
// level of 5000 and phase lengths of 1000 ticks; the output register is emptied.

module trapezoid_speed_profile import tsp_pkg::*; #(
	parameter int unsigned LEVEL_WIDTH = DEF_LEVEL_WIDTH,
	parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	tsp_in_if.sink     tick,
	tsp_out_if.source  result,
	tsp_cfg_if.sink    cfg
);

	localparam int unsigned PROD_W = LEVEL_WIDTH + COUNT_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIVST,
		S_DIV,
		S_DONE
	} state_t;

	// Profile registers.
	logic [LEVEL_WIDTH-1:0] level_q;
	logic [COUNT_WIDTH-1:0] rest_q;
	logic [COUNT_WIDTH-1:0] rise_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [COUNT_WIDTH-1:0] fall_q;

	// Sequencer and profile state.
	state_t                 state_q;
	tsp_phase_t             phase_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] num_q;
	logic [COUNT_WIDTH-1:0] den_q;
	logic [PROD_W-1:0]      prod_q;
	logic [LEVEL_WIDTH-1:0] res_q;
	tsp_phase_t             pend_phase_q;

	// Output register.
	logic                   out_valid_q;
	logic [LEVEL_WIDTH-1:0] out_level_q;
	tsp_phase_t             out_phase_q;

	// Next-state decode for one tick.
	tsp_phase_t             nxt_phase;
	logic [COUNT_WIDTH-1:0] nxt_count;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic                   need_div;
	logic [COUNT_WIDTH-1:0] num_d;
	logic [COUNT_WIDTH-1:0] den_d;
	logic [LEVEL_WIDTH-1:0] direct_sp;

	logic                   tick_xfer;
	logic                   div_start;
	logic [LEVEL_WIDTH-1:0] div_quot;
	tsp_div_stat_t          div_stat;
	logic [SETPOINT_W+LEVEL_WIDTH-1:0] sp_wide;

	assign tick_xfer = tick.valid && tick.ready;
	assign count_inc = count_q + 1'b1;
	assign div_start = (state_q == S_DIVST);

	// Register writes; the user keeps the block idle whenever one arrives; it is not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_WIDTH'(LEVEL_RESET);
			rest_q  <= COUNT_WIDTH'(TICKS_RESET);
			rise_q  <= COUNT_WIDTH'(TICKS_RESET);
			hold_q  <= COUNT_WIDTH'(TICKS_RESET);
			fall_q  <= COUNT_WIDTH'(TICKS_RESET);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LEVEL: level_q <= cfg.data[LEVEL_WIDTH-1:0];
				REG_REST:  rest_q  <= cfg.data[COUNT_WIDTH-1:0];
				REG_RISE:  rise_q  <= cfg.data[COUNT_WIDTH-1:0];
				REG_HOLD:  hold_q  <= cfg.data[COUNT_WIDTH-1:0];
				REG_FALL:  fall_q  <= cfg.data[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// A phase ends on the tick where the counter has reached its length. A division is
	// only started while the counter is below the length, so the incremented count cannot
	// exceed the divisor and the divisor is never zero when a division is started.
	always_comb begin
		nxt_phase = phase_q;
		nxt_count = count_q;
		need_div  = 1'b0;
		num_d     = count_inc;
		den_d     = rise_q;
		direct_sp = '0;
		case (phase_q)
			PH_REST: begin
				if (tick.run) begin
					if (count_q >= rest_q) begin
						nxt_phase = PH_RISE;
						nxt_count = '0;
					end else begin
						nxt_count = count_inc;
					end
				end
			end
			PH_RISE: begin
				if (count_q >= rise_q) begin
					nxt_phase = PH_HOLD;
					nxt_count = '0;
					direct_sp = level_q;
				end else begin
					nxt_count = count_inc;
					need_div  = 1'b1;
					num_d     = count_inc;
					den_d     = rise_q;
				end
			end
			PH_HOLD: begin
				direct_sp = level_q;
				if (count_q >= hold_q) begin
					nxt_phase = PH_FALL;
					nxt_count = '0;
				end else begin
					nxt_count = count_inc;
				end
			end
			PH_FALL: begin
				if (count_q >= fall_q) begin
					nxt_phase = PH_REST;
					nxt_count = '0;
				end else begin
					nxt_count = count_inc;
					need_div  = 1'b1;
					num_d     = fall_q - count_inc;
					den_d     = fall_q;
				end
			end
			default: begin
				nxt_phase = PH_REST;
				nxt_count = '0;
			end
		endcase
	end

	// Sequencer: the profile state is committed when the tick is taken, a ramp value
	// goes through the multiplier and the shared divider, and the result waits in
	// S_DONE until the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_REST;
			count_q      <= '0;
			num_q        <= '0;
			den_q        <= '0;
			prod_q       <= '0;
			res_q        <= '0;
			pend_phase_q <= PH_REST;
			out_valid_q  <= 1'b0;
			out_level_q  <= '0;
			out_phase_q  <= PH_REST;
		end else begin
			// In S_DONE the output register is handled by the reload below.
			if (out_valid_q && result.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick_xfer) begin
						phase_q      <= nxt_phase;
						count_q      <= nxt_count;
						pend_phase_q <= nxt_phase;
						num_q        <= num_d;
						den_q        <= den_d;
						res_q        <= direct_sp;
						state_q      <= need_div ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(level_q) * PROD_W'(num_q);
					state_q <= S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						res_q   <= div_quot;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_level_q <= res_q;
						out_phase_q <= pend_phase_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	tsp_div #(
		.Q_W   (LEVEL_WIDTH),
		.DEN_W (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (den_q),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// The setpoint field is narrower or wider than the level depending on LEVEL_WIDTH.
	assign sp_wide = {{SETPOINT_W{1'b0}}, out_level_q};

	assign tick.ready      = (state_q == S_IDLE);
	assign result.valid    = out_valid_q;
	assign result.setpoint = sp_wide[SETPOINT_W-1:0];
	assign result.phase    = out_phase_q;

	`TSP_ASSERT_NXT(a_busy_after_tick, tick_xfer, !tick.ready, "tick taken while busy")
	`TSP_ASSERT_IMP(a_div_not_ready, div_stat.busy, !tick.ready, "ready during division")
	`TSP_ASSERT_IMP(a_div_done_state, div_stat.done, state_q == S_DIV, "stray divider done")
	`TSP_ASSERT_IMP(a_rest_zero, result.valid && (result.phase == PH_REST),
		result.setpoint == '0, "non-zero setpoint at rest")

endmodule

FILE: sim/trapezoid_speed_profile_tb.sv
// Self-checking testbench for the trapezoidal speed profile generator.
`timescale 1ns / 1ps

module trapezoid_speed_profile_tb;
	import tsp_pkg::*;

	// Register indexes that the block does not decode. Writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	// Chance in a hundred, drawn at each rising edge, that either side idles.
	localparam int unsigned IDLE_PCT = 18;
	// Number of random ticks to send after the directed part.
	localparam int unsigned RANDOM_TICKS = 1650;
	// Cycles allowed after the last result before the final verdict.
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned MAX_REPORTS = 10;

	// One result transfer as the block should present it.
	typedef struct packed {
		logic [SETPOINT_W-1:0] setpoint;
		tsp_phase_t            phase;
	} profile_out_t;

	logic clk;
	logic arst_n;

	tsp_in_if  tick_ch ();
	tsp_out_if result_ch ();
	tsp_cfg_if cfg_ch ();

	trapezoid_speed_profile i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// The testbench's own copy of the profile registers and sequencer state.
	logic [15:0] model_level;
	logic [15:0] model_rest;
	logic [15:0] model_rise;
	logic [15:0] model_hold;
	logic [15:0] model_fall;
	tsp_phase_t  model_phase;
	logic [15:0] model_count;

	// Run flags waiting to be sent, and setpoints still owed by the block.
	bit           run_flags_pending[$];
	profile_out_t setpoint_due[$];

	// When set, neither the tick sender nor the result receiver idles.
	bit steady_flow;

	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned ramp_ticks;
	int unsigned profiles_done;
	int unsigned cfg_writes;

	always #1 clk = ~clk;

	// Advances the model by one control tick and returns the result that tick should give.
	function automatic profile_out_t advance_profile(bit run);
		profile_out_t outp;
		logic [31:0]  product;
		logic [15:0]  sp;

		sp = '0;
		case (model_phase)
			PH_REST: begin
				if (run) begin
					if (model_count >= model_rest) begin
						model_phase = PH_RISE;
						model_count = '0;
					end else begin
						model_count = model_count + 16'd1;
					end
				end
			end
			PH_RISE: begin
				if (model_count >= model_rise) begin
					// Last tick of the ramp: the setpoint has reached the plateau.
					model_phase = PH_HOLD;
					model_count = '0;
					sp = model_level;
				end else begin
					// The count is below a non-zero length here, so the divisor is never zero.
					model_count = model_count + 16'd1;
					product = 32'(model_level) * 32'(model_count);
					sp = 16'(product / 32'(model_rise));
					ramp_ticks++;
				end
			end
			PH_HOLD: begin
				sp = model_level;
				if (model_count >= model_hold) begin
					model_phase = PH_FALL;
					model_count = '0;
				end else begin
					model_count = model_count + 16'd1;
				end
			end
			default: begin
				if (model_count >= model_fall) begin
					model_phase = PH_REST;
					model_count = '0;
					profiles_done++;
				end else begin
					model_count = model_count + 16'd1;
					product = 32'(model_level) * 32'(model_fall - model_count);
					sp = 16'(product / 32'(model_fall));
					ramp_ticks++;
				end
			end
		endcase
		outp.setpoint = sp;
		outp.phase = model_phase;
		return outp;
	endfunction

	// Register writes keep only the low sixteen bits; unknown indexes change nothing.
	function automatic void apply_profile_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_LEVEL: model_level = value[15:0];
			REG_REST:  model_rest = value[15:0];
			REG_RISE:  model_rise = value[15:0];
			REG_HOLD:  model_hold = value[15:0];
			REG_FALL:  model_fall = value[15:0];
			default: ;
		endcase
	endfunction

	// Tick sender. When a transfer completes, the model is stepped and the expected result
	// is queued; a new tick is then offered if one is pending, unless the sender decides to idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready)
				setpoint_due.push_back(advance_profile(tick_ch.run));
			if (!tick_ch.valid || tick_ch.ready) begin
				if (run_flags_pending.size() != 0 &&
						(steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
					tick_ch.valid <= 1'b1;
					tick_ch.run <= run_flags_pending.pop_front();
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random back-pressure, lifted while the steady stretch runs.
	always @(posedge clk) begin
		if (arst_n)
			result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Result checker. Every transfer is matched against the oldest outstanding expectation.
	always @(posedge clk) begin
		profile_out_t want;

		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (setpoint_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with nothing outstanding: setpoint %0d phase %0d",
						$realtime, result_ch.setpoint, result_ch.phase);
			end else begin
				want = setpoint_due.pop_front();
				results_checked++;
				if (result_ch.setpoint !== want.setpoint || result_ch.phase !== want.phase) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected setpoint %0d phase %0d, got setpoint %0d phase %0d",
							$realtime, want.setpoint, want.phase,
							result_ch.setpoint, result_ch.phase);
				end
			end
		end
	end

	// Queues a number of ticks that all carry the same run flag.
	task automatic queue_ticks(bit run, int unsigned n);
		repeat (n)
			run_flags_pending.push_back(run);
	endtask

	// Waits until every tick has been sent and every result received, and returns on a
	// rising edge.
	task automatic wait_until_settled();
		do
			@(posedge clk);
		while (run_flags_pending.size() != 0 || tick_ch.valid || setpoint_due.size() != 0);
		repeat (4)
			@(posedge clk);
	endtask

	// Offers one register write from the current rising edge and returns at the edge where
	// it transfers. Valid stays high so that consecutive writes follow back to back; the
	// caller lowers it after the last one.
	task automatic write_profile_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		apply_profile_reg(idx, value);
		cfg_writes++;
	endtask

	// Mostly short phases so that many whole profiles fit in the run, with the odd zero
	// length and the odd longer phase.
	function automatic logic [15:0] pick_length();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 8));
		if (r < 97)
			return 16'($urandom_range(9, 40));
		return 16'($urandom_range(41, 200));
	endfunction

	function automatic logic [15:0] pick_level();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h0000;
		if (r < 20)
			return 16'hFFFF;
		return 16'($urandom());
	endfunction

	// Half of the writes carry random rubbish above the register width.
	function automatic logic [CFG_DATA_W-1:0] widen(logic [15:0] value);
		logic [CFG_DATA_W-1:0] upper;

		upper = $urandom_range(0, 1) ? CFG_DATA_W'($urandom()) : '0;
		return {upper[CFG_DATA_W-1:16], value};
	endfunction

	initial begin
		int unsigned sent;
		int unsigned chunk;
		int unsigned phase_no;
		int unsigned part;
		int unsigned idle_run;

		clk = 1'b0;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.run = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LEVEL;
		cfg_ch.data = '0;
		steady_flow = 1'b0;
		mismatch_count = 0;
		results_checked = 0;
		ramp_ticks = 0;
		profiles_done = 0;
		cfg_writes = 0;

		// The model starts from the reset contents of the block.
		model_level = 16'(LEVEL_RESET);
		model_rest = 16'(TICKS_RESET);
		model_rise = 16'(TICKS_RESET);
		model_hold = 16'(TICKS_RESET);
		model_fall = 16'(TICKS_RESET);
		model_phase = PH_REST;
		model_count = '0;

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed part. With the reset lengths, a low run flag must hold the count and a
		// high one must count up while the setpoint stays at zero.
		queue_ticks(1'b0, 2);
		queue_ticks(1'b1, 2);
		wait_until_settled();

		// A short profile at the reset level of 5000: the rest phase is already over, the
		// ramps are three and two ticks long and the plateau has zero length.
		write_profile_reg(REG_REST, 32'd1);
		write_profile_reg(REG_RISE, 32'd3);
		write_profile_reg(REG_HOLD, 32'd0);
		write_profile_reg(REG_FALL, 32'd2);
		cfg_ch.valid <= 1'b0;
		queue_ticks(1'b1, 9);
		wait_until_settled();

		// Full-scale level and the longest rising ramp. The level is written with every
		// upper bit set, which must be masked away. A zero rest length still waits for run.
		write_profile_reg(REG_LEVEL, 32'hFFFF_FFFF);
		write_profile_reg(REG_REST, 32'd0);
		write_profile_reg(REG_RISE, 32'h0000_FFFF);
		cfg_ch.valid <= 1'b0;
		queue_ticks(1'b0, 1);
		queue_ticks(1'b1, 4);
		wait_until_settled();

		// Shorten the ramp below the count already reached, so it ends at once; the plateau
		// has zero length and the falling ramp is the longest one. A write to a spare index
		// sits in between and must not disturb anything.
		write_profile_reg(REG_RISE, 32'd0);
		write_profile_reg(REG_SPARE_FIRST, 32'd1);
		write_profile_reg(REG_HOLD, 32'd0);
		write_profile_reg(REG_FALL, 32'd65535);
		cfg_ch.valid <= 1'b0;
		queue_ticks(1'b1, 5);
		wait_until_settled();

		// End the falling ramp early and drop the level to zero, idle at rest, then start again.
		write_profile_reg(REG_FALL, 32'hA5A5_0001);
		write_profile_reg(REG_LEVEL, 32'd0);
		write_profile_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
		cfg_ch.valid <= 1'b0;
		queue_ticks(1'b1, 1);
		queue_ticks(1'b0, 1);
		queue_ticks(1'b1, 2);
		wait_until_settled();

		// Random part. Each round loads a fresh profile while the block is idle and then
		// sends a burst of ticks, mostly with run high so that whole profiles go by, with
		// short bursts of run low as noise. Rounds three to five run without any idling.
		sent = 0;
		phase_no = 0;
		while (sent < RANDOM_TICKS) begin
			steady_flow = (phase_no >= 3 && phase_no <= 5);
			if ($urandom_range(0, 2) == 0)
				write_profile_reg(
					CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
					CFG_DATA_W'($urandom()));
			write_profile_reg(REG_LEVEL, widen(pick_level()));
			write_profile_reg(REG_REST, widen(pick_length()));
			write_profile_reg(REG_RISE, widen(pick_length()));
			write_profile_reg(REG_HOLD, widen(pick_length()));
			write_profile_reg(REG_FALL, widen(pick_length()));
			cfg_ch.valid <= 1'b0;

			chunk = $urandom_range(40, 120);
			for (part = 0; part < chunk; part++) begin
				if ($urandom_range(0, 99) < 6) begin
					idle_run = $urandom_range(1, 4);
					queue_ticks(1'b0, idle_run);
					sent += idle_run;
				end else begin
					queue_ticks(1'b1, 1);
					sent += 1;
				end
				// Now and then the sender stops part way through until the block is empty.
				if (part == chunk / 2 && $urandom_range(0, 3) == 0)
					wait_until_settled();
			end
			wait_until_settled();
			phase_no++;
		end
		steady_flow = 1'b0;

		wait_until_settled();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (setpoint_due.size() != 0) begin
			$display("%0d expected results never arrived", setpoint_due.size());
			mismatch_count += setpoint_due.size();
		end

		$display("Checked %0d setpoints over %0d profile settings and %0d register writes.",
			results_checked, phase_no + 5, cfg_writes);
		$display("%0d ticks fell on a ramp, %0d profiles ran through to rest, %0d mismatches.",
			ramp_ticks, profiles_done, mismatch_count);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog: fails the run if it has not finished within the timeout below.
	initial begin
		#2_000_000;
		$display("Timed out with %0d ticks unsent and %0d results outstanding.",
			run_flags_pending.size(), setpoint_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
